### rtl/dt4_pkg.sv
// ----------------------------------------------------------------------------
// dt4_pkg: shared types and constants for the D4 distance transform
// Item payloads, distance format and control bundle for the window cells.
// ----------------------------------------------------------------------------
package dt4_pkg;

  localparam int DIST_BITS = 8;
  localparam int CFG_W     = 11;

  typedef logic [DIST_BITS-1:0] dist_t;

  localparam dist_t            DIST_MAX    = {DIST_BITS{1'b1}};
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

  typedef struct packed {
    logic foreground;
    logic start_of_image;
  } dt4_in_t;

  typedef struct packed {
    dist_t distance;
    logic  end_of_row;
  } dt4_out_t;

  // load strobe and source selection for one window cell
  typedef struct packed {
    logic load;
    logic take_mem;
    logic fwd_hit;
    logic mem_ok;
  } cell_ctl_t;

endpackage

### rtl/dt4_cell.sv
// ----------------------------------------------------------------------------
// dt4_cell: one cell of the neighborhood window chain
// Holds one distance value; on load takes it from its neighbor, from the
// forwarded write data, from line-store read data, or zero.
// ----------------------------------------------------------------------------
module dt4_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dt4_pkg::cell_ctl_t ctl,
  input  dt4_pkg::dist_t    nbr_val,
  input  dt4_pkg::dist_t    fwd_val,
  input  dt4_pkg::dist_t    mem_q,
  output dt4_pkg::dist_t    cell_val
);
  import dt4_pkg::*;

  dist_t val_r;
  logic  use_q_r;

  // use_q_r selects the registered store read that arrives with the load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_q_r <= 1'b0;
    end else if (ctl.load) begin
      use_q_r <= ctl.take_mem && !ctl.fwd_hit && ctl.mem_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (!ctl.take_mem) begin
        val_r <= nbr_val;
      end else if (ctl.fwd_hit) begin
        val_r <= fwd_val;
      end else begin
        val_r <= '0;
      end
    end
  end

  assign cell_val = use_q_r ? mem_q : val_r;

endmodule

### rtl/translated_d4_distance_transform.sv
// ----------------------------------------------------------------------------
// translated_d4_distance_transform: raster-order translated city-block DT
// One pixel in, one distance out. Two line stores keep the last two rows;
// a chain of window cells carries the previous-row neighbors along the row.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-------------------
//  input   | in_valid, in_stall, in_data    | in        | dt4_in_t (pixel)
//  result  | out_valid, out_stall, out_data | out       | dt4_out_t (distance)
//  config  | cfg_valid, cfg_ready, cfg_data | in        | image width, 11 bits
//
//  Flow: one item per clock while the output is not stalled; an accepted
//  item passes the store read stage, then the output register, and
//  out_valid rises when it lands in the output register.
//  The rate is set by the combinational four-way minimum and one store write
//  port per row store.
//  Reset: synchronous, active low; width returns to 1024. There is no clearing
//  pass: a fill count marks the columns written since the last start of image,
//  and store entries beyond it read as zero.
//  Stalls: out_stall holds the output register; in_stall rises only while
//  both the read stage and the output register are full and the output is
//  stalled. cfg_ready is always high.
//
module translated_d4_distance_transform #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dt4_pkg::dt4_in_t            in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output dt4_pkg::dt4_out_t           out_data,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dt4_pkg::CFG_W-1:0]   cfg_data
);
  import dt4_pkg::*;

  // AW indexes a column, CW counts columns up to MAX_COLUMNS
  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int WB = (CW > CFG_W) ? CW : CFG_W;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] width_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_data;
    end
  end

  // clamp the width to 1..MAX_COLUMNS
  logic [WB-1:0] width_ext;
  logic [CW-1:0] width_eff;

  assign width_ext = WB'(width_r);

  always_comb begin
    if (width_r == '0) begin
      width_eff = CW'(1);
    end else if (width_ext > WB'(MAX_COLUMNS)) begin
      width_eff = CW'(MAX_COLUMNS);
    end else begin
      width_eff = width_ext[CW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // handshake and pipeline control
  // --------------------------------------------------------------------------
  logic b_vld_r, b_vld_nxt;
  logic o_vld_r, o_vld_nxt;
  logic b_go;
  logic accept;

  // read stage drains into the output register when it is empty or taken
  assign b_go     = b_vld_r && (!o_vld_r || !out_stall);
  assign in_stall = b_vld_r && !b_go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    b_vld_nxt = b_vld_r;
    if (accept) begin
      b_vld_nxt = 1'b1;
    end else if (b_go) begin
      b_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    o_vld_nxt = o_vld_r;
    if (b_go) begin
      o_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      o_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // accept stage: column position, row end, fill count
  // --------------------------------------------------------------------------
  logic [AW-1:0] col_r, col_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] col_a;
  logic [CW-1:0] col_a_ext;
  logic [CW-1:0] col1_a;
  logic          last_a;
  logic          sof_a;

  assign sof_a     = in_data.start_of_image;
  assign col_a     = sof_a ? '0 : col_r;
  assign col_a_ext = CW'(col_a);
  assign col1_a    = col_a_ext + CW'(1);
  // a width cut below the current column ends the row here
  assign last_a    = col1_a >= width_eff;

  always_comb begin
    col_nxt = last_a ? '0 : col1_a[AW-1:0];
    if (sof_a) begin
      fill_nxt = CW'(1);
    end else if (col_a_ext == fill_r) begin
      fill_nxt = fill_r + CW'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      fill_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      fill_r <= fill_nxt;
    end
  end

  // item state carried into the read stage
  logic [AW-1:0] b_col_r;
  logic          b_last_r;
  logic          b_fg_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r  <= col_a;
      b_last_r <= last_a;
      b_fg_r   <= in_data.foreground;
    end
  end

  // --------------------------------------------------------------------------
  // line stores: written by the item leaving the read stage, read at accept
  // --------------------------------------------------------------------------
  dist_t prev_row_mem_r [MAX_COLUMNS];
  dist_t sec_row_mem_r  [MAX_COLUMNS];
  dist_t prev_qa_r;   // previous row, column col+1
  dist_t prev_qb_r;   // previous row, column col
  dist_t sec_q_r;     // two rows up, column col
  dist_t result_b;
  dist_t up_val;

  always_ff @(posedge clk) begin
    if (b_go) begin
      prev_row_mem_r[b_col_r] <= result_b;
      sec_row_mem_r[b_col_r]  <= up_val;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_qa_r <= prev_row_mem_r[col1_a[AW-1:0]];
      prev_qb_r <= prev_row_mem_r[col_a];
      sec_q_r   <= sec_row_mem_r[col_a];
    end
  end

  // --------------------------------------------------------------------------
  // window cell chain: up-right -> up -> left, plus up-up
  // --------------------------------------------------------------------------
  // A write leaving the read stage in the same cycle as a read of the same
  // column is forwarded. A start of image masks every read to zero, and so
  // does a column beyond the fill count.
  cell_ctl_t ctl_ur, ctl_up, ctl_lf, ctl_uu;
  dist_t     ur_val, left_val, uu_val;
  logic      hit_col, hit_col1;
  logic      ok_col;

  assign hit_col  = !sof_a && b_go && (b_col_r == col_a);
  assign hit_col1 = !sof_a && b_go && (b_col_r == col1_a[AW-1:0]);
  assign ok_col   = !sof_a && (col_a_ext < fill_r);

  always_comb begin
    ctl_ur.load     = accept;
    ctl_ur.take_mem = 1'b1;
    ctl_ur.fwd_hit  = hit_col1 && !last_a;
    ctl_ur.mem_ok   = !sof_a && !last_a && (col1_a < fill_r);

    // within a row the up value is the last item's up-right
    ctl_up.load     = accept;
    ctl_up.take_mem = (col_a == '0);
    ctl_up.fwd_hit  = hit_col;
    ctl_up.mem_ok   = ok_col;

    // left is the last item's up; zero at the left border
    ctl_lf.load     = accept;
    ctl_lf.take_mem = (col_a == '0);
    ctl_lf.fwd_hit  = 1'b0;
    ctl_lf.mem_ok   = 1'b0;

    ctl_uu.load     = accept;
    ctl_uu.take_mem = 1'b1;
    ctl_uu.fwd_hit  = hit_col;
    ctl_uu.mem_ok   = ok_col;
  end

  dt4_cell u_cell_ur (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_ur),
    .nbr_val  ('0),
    .fwd_val  (result_b),
    .mem_q    (prev_qa_r),
    .cell_val (ur_val)
  );

  dt4_cell u_cell_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_up),
    .nbr_val  (ur_val),
    .fwd_val  (result_b),
    .mem_q    (prev_qb_r),
    .cell_val (up_val)
  );

  dt4_cell u_cell_lf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_lf),
    .nbr_val  (up_val),
    .fwd_val  (result_b),
    .mem_q    (prev_qb_r),
    .cell_val (left_val)
  );

  dt4_cell u_cell_uu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_uu),
    .nbr_val  ('0),
    .fwd_val  (up_val),
    .mem_q    (sec_q_r),
    .cell_val (uu_val)
  );

  // --------------------------------------------------------------------------
  // read stage: zero for background, else four-way minimum, increment, saturate
  // --------------------------------------------------------------------------
  dist_t min_a, min_b, min_all;

  always_comb begin
    min_a   = (left_val < up_val) ? left_val : up_val;
    min_b   = (ur_val < uu_val) ? ur_val : uu_val;
    min_all = (min_a < min_b) ? min_a : min_b;
    if (!b_fg_r) begin
      result_b = '0;
    end else if (min_all == DIST_MAX) begin
      result_b = DIST_MAX;
    end else begin
      result_b = min_all + dist_t'(1);
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  dt4_out_t o_data_r;

  always_ff @(posedge clk) begin
    if (b_go) begin
      o_data_r.distance   <= result_b;
      o_data_r.end_of_row <= b_last_r;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (b_vld_r && o_vld_r && out_stall))
    else $error("input stalled while the pipeline can advance");

  a_drain_lands: assert property (@(posedge clk) disable iff (!rst_n)
    b_go |=> o_vld_r)
    else $error("item left the read stage but the output register is empty");

  a_sof_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.start_of_image) |=> (fill_r == CW'(1)))
    else $error("fill count not restarted by start of image");

  a_left_border: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && (b_col_r == '0)) |-> (left_val == '0))
    else $error("left neighbor not zero at column zero");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_COLUMNS))
    else $error("fill count beyond the store depth");

endmodule
